### src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CHK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CHK(label, prop)
`define ASSERT_NEVER(label, expr)
`endif
`endif

### src/cgsd_pkg.sv
// ---------------------------------------------------------------------------
// cgsd_pkg
// Constants and types of the cadence gear shift detector.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cgsd_pkg;

  localparam int unsigned HISTORY_DEPTH = 12;
  localparam int unsigned TIME_WIDTH    = 32;
  localparam int unsigned IDX_W         = $clog2(HISTORY_DEPTH);

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned LIMIT_W  = 16;
  localparam int unsigned CFG_AW   = 2;
  localparam int unsigned CFG_DW   = 16;
  localparam int unsigned IN_DW    = 16;
  localparam int unsigned OUT_DW   = 8;

  localparam logic [CFG_AW-1:0] CFG_LOW_THR  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_HIGH_THR = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_FAST_LIM = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_SLOW_LIM = 2'd3;

  localparam logic [SAMPLE_W-1:0] LOW_THR_RST  = 10'd200;
  localparam logic [SAMPLE_W-1:0] HIGH_THR_RST = 10'd700;
  localparam logic [LIMIT_W-1:0]  FAST_LIM_RST = 16'd225;
  localparam logic [LIMIT_W-1:0]  SLOW_LIM_RST = 16'd450;

  typedef enum logic {
    KIND_TICK   = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    SHIFT_NONE   = 2'd0,
    SHIFT_EASIER = 2'd1,
    SHIFT_HARDER = 2'd2
  } shift_e;

  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic [IDX_W-1:0]      idx_t;

endpackage

### src/cadence_gear_shift_detector.sv
// ---------------------------------------------------------------------------
// cadence_gear_shift_detector
// Hysteresis pass detector on Hall samples, pass-time ring and gear shift
// decision from the span of the last passes.
// ---------------------------------------------------------------------------
// An accepted item's result is written to the output register as it is accepted.
// Throughput: one item per cycle unless the output stalls; the ring read, span
// compare and ring write all settle between the input handshake and the output
// register. Input is taken while the output register is empty or being drained.
// Reset: asynchronous, active low; clears time counter, ring, index, level
// and output valid, and loads the threshold and limit defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cadence_gear_shift_detector
  import cgsd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_DW-1:0]  s_axis_tdata,   // [9:0] sample_value, [15:10] zero
  input  logic [0:0]        s_axis_tuser,   // [0] kind
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_DW-1:0] m_axis_tdata    // [1:0] shift_request, [2] pass_detected
);

  logic [SAMPLE_W-1:0] low_thr_q, high_thr_q;
  logic [LIMIT_W-1:0]  fast_lim_q, slow_lim_q;

  time_t tick_count_q, tick_count_d;
  time_t pass_times_q [HISTORY_DEPTH];
  idx_t  ring_index_q, ring_index_d;
  logic  level_low_q, level_low_d;

  logic   out_valid_q;
  shift_e shift_q, shift_d;
  logic   pass_q, pass_d;

  logic                accept;
  logic [SAMPLE_W-1:0] sample;
  kind_e               kind;
  idx_t                wr_idx, old_idx;
  time_t               oldest, span;
  logic                ring_wr, ring_clr;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign sample        = s_axis_tdata[SAMPLE_W-1:0];
  assign kind          = kind_e'(s_axis_tuser[0]);

  assign wr_idx  = (ring_index_q == idx_t'(HISTORY_DEPTH - 1)) ? '0 : ring_index_q + idx_t'(1);
  assign old_idx = (wr_idx == idx_t'(HISTORY_DEPTH - 1)) ? '0 : wr_idx + idx_t'(1);
  assign oldest  = pass_times_q[old_idx];
  assign span    = tick_count_q - oldest;

  always_comb begin
    tick_count_d = tick_count_q;
    ring_index_d = ring_index_q;
    level_low_d  = level_low_q;
    shift_d      = SHIFT_NONE;
    pass_d       = 1'b0;
    ring_wr      = 1'b0;
    ring_clr     = 1'b0;
    if (kind == KIND_TICK) begin
      tick_count_d = tick_count_q + time_t'(1);
    end else if (sample > high_thr_q) begin
      level_low_d = 1'b0;
    end else if (sample < low_thr_q && !level_low_q) begin
      level_low_d  = 1'b1;
      pass_d       = 1'b1;
      ring_wr      = 1'b1;
      ring_index_d = wr_idx;
      if (oldest != '0 && tick_count_q >= oldest) begin
        if (span > time_t'(slow_lim_q)) begin
          shift_d  = SHIFT_EASIER;
          ring_clr = 1'b1;
        end else if (span < time_t'(fast_lim_q)) begin
          shift_d  = SHIFT_HARDER;
          ring_clr = 1'b1;
        end
      end
    end
    if (ring_clr) begin
      ring_index_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q  <= LOW_THR_RST;
      high_thr_q <= HIGH_THR_RST;
      fast_lim_q <= FAST_LIM_RST;
      slow_lim_q <= SLOW_LIM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_LOW_THR:  low_thr_q  <= cfg_data_i[SAMPLE_W-1:0];
        CFG_HIGH_THR: high_thr_q <= cfg_data_i[SAMPLE_W-1:0];
        CFG_FAST_LIM: fast_lim_q <= cfg_data_i[LIMIT_W-1:0];
        CFG_SLOW_LIM: slow_lim_q <= cfg_data_i[LIMIT_W-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_count_q <= '0;
      ring_index_q <= '0;
      level_low_q  <= 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        pass_times_q[i] <= '0;
      end
    end else if (accept) begin
      tick_count_q <= tick_count_d;
      ring_index_q <= ring_index_d;
      level_low_q  <= level_low_d;
      if (ring_clr) begin
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
          pass_times_q[i] <= '0;
        end
      end else if (ring_wr) begin
        pass_times_q[wr_idx] <= tick_count_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      shift_q <= shift_d;
      pass_q  <= pass_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DW - 3){1'b0}}, pass_q, shift_q};

  `ASSERT_CHK(a_shift_needs_pass, (out_valid_q && shift_q != SHIFT_NONE) |-> pass_q)
  `ASSERT_CHK(a_shift_resets_index, (accept && shift_d != SHIFT_NONE) |=> (ring_index_q == '0))
  `ASSERT_CHK(a_pass_sets_low, (accept && pass_d) |=> level_low_q)
  `ASSERT_CHK(a_tick_advances, (accept && kind == KIND_TICK) |=> (tick_count_q == $past(tick_count_q) + time_t'(1)))
  `ASSERT_NEVER(a_pass_on_tick, accept && kind == KIND_TICK && pass_d)

endmodule
